/* rtl/drl_pkg.sv */
// drl_pkg: shared types and constants of the duty ramp limiter
// no dependencies; imported by drl_step and duty_ramp_limiter
`timescale 1ns / 1ps
`default_nettype none

package drl_pkg;

  // command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_SET_TARGET = 2'd0,
    CMD_SET_DUTY   = 2'd1,
    CMD_SET_SPEED  = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic [1:0] REG_RAMP_STEP = 2'd0;
  localparam logic [1:0] REG_SNAP_THR  = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED = 2'd2;

  // register reset values
  localparam logic [14:0] RAMP_STEP_RST = 15'd1638;
  localparam logic [14:0] SNAP_THR_RST  = 15'd3277;
  localparam logic [20:0] MAX_SPEED_RST = 21'd1000000;

  // duty limits and deadbands
  localparam logic signed [21:0] DUTY_FULL_V    = 22'sd32767;
  localparam logic signed [21:0] DUTY_DEADBAND  = 22'sd655;
  localparam logic signed [21:0] SPEED_DEADBAND = 22'sd2;
  localparam logic signed [15:0] DUTY_FULL      = 16'sd32767;
  localparam logic signed [17:0] DUTY_FULL_W    = 18'sd32767;

  // configuration register set
  typedef struct packed {
    logic [14:0] ramp_step;
    logic [14:0] snap_thr;
    logic [20:0] max_speed;
  } drl_cfg_t;

  // controller state
  typedef struct packed {
    logic               mode;
    logic signed [15:0] target;
    logic signed [15:0] duty;
    logic signed [21:0] speed;
  } drl_state_t;

endpackage

`default_nettype wire

/* rtl/drl_step.sv */
// drl_step: next-state and send logic for one command
// depends on drl_pkg
`timescale 1ns / 1ps
`default_nettype none

module drl_step
  import drl_pkg::*;
(
  input  wire cmd_t               cmd,
  input  wire logic signed [21:0] value,
  input  wire drl_cfg_t           cfg,
  input  wire drl_state_t         cur,
  output drl_state_t              nxt,
  output logic                    send
);

  logic signed [15:0] tgt_new;
  logic signed [21:0] spd_new;
  logic signed [22:0] lim;
  logic signed [22:0] v_ext;
  logic signed [15:0] duty_z;
  logic signed [16:0] diff;
  logic signed [16:0] thr;
  logic signed [17:0] stepped;
  logic signed [15:0] duty_ramp;

  // duty deadband and saturation
  always_comb begin
    if (value <= DUTY_DEADBAND && value >= -DUTY_DEADBAND) begin
      tgt_new = '0;
    end else if (value > DUTY_FULL_V) begin
      tgt_new = DUTY_FULL;
    end else if (value < -DUTY_FULL_V) begin
      tgt_new = -DUTY_FULL;
    end else begin
      tgt_new = value[15:0];
    end
  end

  // speed deadband then clamp
  assign lim   = $signed({2'b00, cfg.max_speed});
  assign v_ext = {value[21], value};
  always_comb begin
    if (value <= SPEED_DEADBAND && value >= -SPEED_DEADBAND) begin
      spd_new = '0;
    end else if (v_ext > lim) begin
      spd_new = lim[21:0];
    end else if (v_ext < -lim) begin
      spd_new = 22'(-lim);
    end else begin
      spd_new = value;
    end
  end

  // ramp toward target; a zero target drops the duty first
  assign duty_z = (cur.target == '0) ? '0 : cur.duty;
  assign diff   = 17'({cur.target[15], cur.target} - {duty_z[15], duty_z});
  assign thr    = $signed({2'b00, cfg.snap_thr});
  always_comb begin
    if (diff > 17'sd0) begin
      stepped = 18'({{2{duty_z[15]}}, duty_z} + $signed({3'b000, cfg.ramp_step}));
    end else begin
      stepped = 18'({{2{duty_z[15]}}, duty_z} - $signed({3'b000, cfg.ramp_step}));
    end
    if (diff <= thr && diff >= -thr) begin
      duty_ramp = cur.target;
    end else if (stepped > DUTY_FULL_W) begin
      duty_ramp = DUTY_FULL;
    end else if (stepped < -DUTY_FULL_W) begin
      duty_ramp = -DUTY_FULL;
    end else begin
      duty_ramp = stepped[15:0];
    end
  end

  // command decode
  always_comb begin
    nxt  = cur;
    send = 1'b0;
    case (cmd)
      CMD_SET_TARGET: begin
        nxt.mode   = 1'b0;
        nxt.target = tgt_new;
      end
      CMD_SET_DUTY: begin
        nxt.mode   = 1'b0;
        nxt.target = tgt_new;
        nxt.duty   = tgt_new;
        send       = 1'b1;
      end
      CMD_SET_SPEED: begin
        nxt.mode  = 1'b1;
        nxt.speed = spd_new;
        send      = 1'b1;
      end
      CMD_TICK: begin
        if (!cur.mode) begin
          nxt.duty = duty_ramp;
          send     = 1'b1;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/duty_ramp_limiter.sv */
// duty_ramp_limiter: motor command shaper with deadband and slew limiting
// depends on drl_pkg and drl_step
`timescale 1ns / 1ps
`default_nettype none

// Takes one command transaction per clock while the output side keeps out_tready
// high, and returns one result transaction for each. A command is captured in
// the input register, is decoded against the held controller state by the
// combinational step logic, and the new state and send flag that drive
// out_tdata are registered once the result slot is free. Duty is Q1.15
// saturated to +-32767, speed is in hundredths of RPM clamped to +-max_speed.
// Configuration registers are written through cfg_we / cfg_addr / cfg_wdata;
// write them only while no transaction is in flight.
module duty_ramp_limiter
  import drl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [20:0] cfg_wdata,
  // command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // [21:0] value
  input  wire logic [1:0]  in_tuser,  // [1:0] cmd
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata  // [0] send, [1] mode, [17:2] duty_out,
                                      // [39:18] speed_out
);

  drl_cfg_t           cfg_r;
  drl_state_t         state_r;
  drl_state_t         state_nxt;
  logic               in_valid_r;
  cmd_t               cmd_r;
  logic signed [21:0] value_r;
  logic               out_valid_r;
  logic               send_r;
  logic               send_nxt;
  logic               out_free;
  logic               fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_step <= RAMP_STEP_RST;
      cfg_r.snap_thr  <= SNAP_THR_RST;
      cfg_r.max_speed <= MAX_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RAMP_STEP: cfg_r.ramp_step <= cfg_wdata[14:0];
        REG_SNAP_THR:  cfg_r.snap_thr  <= cfg_wdata[14:0];
        REG_MAX_SPEED: cfg_r.max_speed <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // handshake: the input stage moves on when the result slot frees up
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= cmd_t'(in_tuser);
      value_r <= $signed(in_tdata[21:0]);
    end
  end

  // step logic
  drl_step u_step (
    .cmd   (cmd_r),
    .value (value_r),
    .cfg   (cfg_r),
    .cur   (state_r),
    .nxt   (state_nxt),
    .send  (send_nxt)
  );

  // controller state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      send_r <= send_nxt;
    end
  end

  // result fields come from the state just written
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {state_r.speed, state_r.duty, state_r.mode, send_r};

`ifndef SYNTH
  // a staged command always produces a result when the slot is empty
  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_valid_r |=> out_valid_r)
    else $error("staged command did not reach the result register");

  // duty never reaches the negative full-scale code
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.duty != 16'sh8000 && state_r.target != 16'sh8000)
    else $error("duty outside +-32767");

  // state moves only when a command is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("state changed without a command");

  // a tick in velocity mode sends nothing and leaves duty alone
  a_vel_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd_r == CMD_TICK && state_r.mode |=> !send_r && $stable(state_r.duty))
    else $error("tick acted in velocity mode");
`endif

endmodule

`default_nettype wire

/* sim/testbench.sv */
// testbench: self-checking bench for the duty ramp limiter command shaper
// depends on drl_pkg and duty_ramp_limiter; random stimulus, in-bench predictor
`timescale 1ns / 1ps

module testbench;
  import drl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // result fields, packed in the same order as out_tdata
  typedef struct packed {
    logic signed [21:0] speed;
    logic signed [15:0] duty;
    logic               mode;
    logic               send;
  } drive_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [20:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  // shaper model: registers and controller state
  logic [14:0] step_reg = RAMP_STEP_RST;
  logic [14:0] snap_reg = SNAP_THR_RST;
  logic [20:0] speed_lim_reg = MAX_SPEED_RST;
  logic        velocity_mode = 1'b0;
  int          target_duty = 0;
  int          applied_duty = 0;
  int          applied_speed = 0;

  drive_result_t pending_results[$];
  int mismatch_count = 0;
  int command_count = 0;
  int result_count = 0;
  int setting_count = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;

  duty_ramp_limiter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),  // [21:0] value
    .in_tuser  (in_tuser),  // [1:0] cmd
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)  // [0] send, [1] mode, [17:2] duty_out, [39:18] speed_out
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stalls about one cycle in ten
  always @(posedge clk) begin
    if (quiet)
      out_tready <= 1'b1;
    else
      out_tready <= ($urandom_range(0, 99) >= 10);
  end

  // duty deadband and saturation, selects duty mode
  function automatic void load_target(input int v);
    velocity_mode = 1'b0;
    if (v <= int'(DUTY_DEADBAND) && v >= -int'(DUTY_DEADBAND))
      target_duty = 0;
    else if (v > int'(DUTY_FULL_V))
      target_duty = int'(DUTY_FULL_V);
    else if (v < -int'(DUTY_FULL_V))
      target_duty = -int'(DUTY_FULL_V);
    else
      target_duty = v;
  endfunction

  // apply one command to the model state and return the drive result
  function automatic drive_result_t shape_command(input cmd_t c, input logic signed [21:0] v);
    drive_result_t r;
    int val;
    int lim;
    int thr;
    int diff;
    val = v;
    lim = int'(speed_lim_reg);
    thr = int'(snap_reg);
    r.send = 1'b0;
    case (c)
      CMD_SET_TARGET: begin
        load_target(val);
      end
      CMD_SET_DUTY: begin
        load_target(val);
        applied_duty = target_duty;
        r.send = 1'b1;
      end
      CMD_SET_SPEED: begin
        velocity_mode = 1'b1;
        if (val <= int'(SPEED_DEADBAND) && val >= -int'(SPEED_DEADBAND))
          val = 0;
        else if (val > lim)
          val = lim;
        else if (val < -lim)
          val = -lim;
        applied_speed = val;
        r.send = 1'b1;
      end
      default: begin
        // tick only ramps in duty mode
        if (!velocity_mode) begin
          if (target_duty == 0)
            applied_duty = 0;
          if (target_duty != applied_duty) begin
            diff = target_duty - applied_duty;
            if (diff <= thr && diff >= -thr)
              applied_duty = target_duty;
            else if (diff > 0)
              applied_duty = applied_duty + int'(step_reg);
            else
              applied_duty = applied_duty - int'(step_reg);
            if (applied_duty > int'(DUTY_FULL_V))
              applied_duty = int'(DUTY_FULL_V);
            if (applied_duty < -int'(DUTY_FULL_V))
              applied_duty = -int'(DUTY_FULL_V);
          end
          r.send = 1'b1;
        end
      end
    endcase
    r.mode  = velocity_mode;
    r.duty  = applied_duty[15:0];
    r.speed = applied_speed[21:0];
    return r;
  endfunction

  // predict on each accepted command, check each accepted result
  always @(posedge clk) begin : monitor
    drive_result_t want;
    drive_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(shape_command(cmd_t'(in_tuser), in_tdata[21:0]));
        command_count++;
      end
      if (out_tvalid && out_tready) begin
        result_count++;
        got = drive_result_t'(out_tdata);
        if (pending_results.size() == 0) begin
          $error("result transaction with no command waiting");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.send !== want.send) begin
            $error("send: expected %0d, got %0d", want.send, got.send);
            mismatch_count++;
          end
          if (got.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, got.mode);
            mismatch_count++;
          end
          if (got.duty !== want.duty) begin
            $error("duty_out: expected %0d, got %0d", want.duty, got.duty);
            mismatch_count++;
          end
          if (got.speed !== want.speed) begin
            $error("speed_out: expected %0d, got %0d", want.speed, got.speed);
            mismatch_count++;
          end
        end
      end
    end
  end

  // send one command transaction, with random gaps ahead of it
  task automatic send_cmd(input cmd_t c, input logic signed [21:0] v);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, v};
    in_tuser  <= c;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one register write, model follows at once
  task automatic set_register(input logic [1:0] idx, input logic [20:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_RAMP_STEP: step_reg = data[14:0];
      REG_SNAP_THR:  snap_reg = data[14:0];
      default:       speed_lim_reg = data;
    endcase
  endtask

  task automatic apply_settings(input logic [14:0] step, input logic [14:0] thr,
                                input logic [20:0] lim);
    drain_results();
    set_register(REG_RAMP_STEP, {6'd0, step});
    set_register(REG_SNAP_THR, {6'd0, thr});
    set_register(REG_MAX_SPEED, lim);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // value mix: deadbands, duty range, speed range, extremes, anything
  function automatic logic signed [21:0] random_value();
    int v;
    int lim;
    lim = int'(speed_lim_reg);
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 1400)) - 700;
      1: v = int'($urandom_range(0, 66000)) - 33000;
      2: v = int'($urandom_range(0, 10)) - 5;
      3: begin
        v = int'($urandom_range(0, 2 * lim + 20)) - lim - 10;
        if (v > 2097151)
          v = 2097151;
        if (v < -2097152)
          v = -2097152;
      end
      4: begin
        case ($urandom_range(0, 7))
          0: v = 2097151;
          1: v = -2097152;
          2: v = 32767;
          3: v = -32767;
          4: v = 32768;
          5: v = -32768;
          6: v = 656;
          default: v = -656;
        endcase
      end
      default: v = int'($urandom());
    endcase
    return v[21:0];
  endfunction

  // mostly a target followed by a run of ticks, the rest loose commands
  task automatic run_random(input int n);
    int sent;
    int k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 70) begin
        send_cmd(($urandom_range(0, 3) == 0) ? CMD_SET_DUTY : CMD_SET_TARGET,
                 random_value());
        k = $urandom_range(1, 40);
        repeat (k) send_cmd(CMD_TICK, 22'($urandom()));
        sent += k + 1;
      end else begin
        send_cmd(cmd_t'($urandom_range(0, 3)), random_value());
        sent++;
      end
    end
  endtask

  // deadband edges and saturation of duty commands
  task automatic test_duty_deadband();
    send_cmd(CMD_SET_TARGET, 22'sd655);
    send_cmd(CMD_SET_TARGET, -22'sd655);
    send_cmd(CMD_SET_TARGET, 22'sd656);
    send_cmd(CMD_SET_TARGET, -22'sd656);
    send_cmd(CMD_SET_TARGET, 22'sd2097151);
    send_cmd(CMD_SET_TARGET, -22'sd2097152);
  endtask

  task automatic test_set_duty_now();
    send_cmd(CMD_SET_DUTY, 22'sd32768);
    send_cmd(CMD_SET_DUTY, -22'sd32768);
  endtask

  // zero target zeroes duty, ramp up by steps, then snap down
  task automatic test_ramp_ticks();
    send_cmd(CMD_SET_TARGET, 22'sd0);
    send_cmd(CMD_TICK, 22'sd0);
    send_cmd(CMD_SET_TARGET, 22'sd32767);
    repeat (3) send_cmd(CMD_TICK, -22'sd1);
    send_cmd(CMD_SET_TARGET, 22'sd2000);
    send_cmd(CMD_TICK, 22'sd0);
  endtask

  // speed deadband, clamp, and ticks ignored in velocity mode
  task automatic test_speed_clamp();
    send_cmd(CMD_SET_SPEED, 22'sd2);
    send_cmd(CMD_SET_SPEED, -22'sd2);
    send_cmd(CMD_SET_SPEED, 22'sd3);
    send_cmd(CMD_SET_SPEED, -22'sd3);
    send_cmd(CMD_SET_SPEED, 22'sd2097151);
    send_cmd(CMD_SET_SPEED, -22'sd2097152);
    send_cmd(CMD_TICK, 22'sd0);
  endtask

  task automatic test_default_ramp();
    run_random(120);
    drain_results();
    run_random(120);
  endtask

  task automatic test_register_extremes();
    apply_settings(15'd1, 15'd0, 21'd0);
    run_random(150);
    apply_settings(15'd32767, 15'd32767, 21'd2097151);
    run_random(150);
    apply_settings(15'd0, 15'd0, 21'($urandom_range(0, 2097151)));
    run_random(120);
    apply_settings(15'd32767, 15'd0, 21'd1);
    run_random(150);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      apply_settings(15'($urandom_range(1, 6000)), 15'($urandom_range(0, 8000)),
                     21'($urandom_range(0, 2097151)));
      run_random(130);
    end
    // a stretch with no idling on either side
    apply_settings(15'($urandom()), 15'($urandom()), 21'($urandom()));
    quiet = 1'b1;
    run_random(130);
    drain_results();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_duty_deadband();
    test_set_duty_now();
    test_ramp_ticks();
    test_speed_clamp();
    test_default_ramp();
    test_register_extremes();
    test_random_settings();
    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d commands sent under %0d register settings, %0d results checked",
             command_count, setting_count + 1, result_count);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
